// File: rtl/sensor_request_response_reader_assert.svh
// ----------------------------------------------------------------------------
// sensor_request_response_reader assertion macros
// concurrent assertion helpers, empty when synthesised
// ----------------------------------------------------------------------------
`ifndef SENSOR_REQUEST_RESPONSE_READER_ASSERT_SVH
`define SENSOR_REQUEST_RESPONSE_READER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SRR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define SRR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`define SRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// shared types and constants of the sensor request/response reader
// ----------------------------------------------------------------------------
package srr_pkg;

    localparam int unsigned TIMER_W = 24;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ADDR_W  = 3;

    localparam logic [TIMER_W-1:0] RESPONSE_TIMEOUT_RST = 24'd20000;
    localparam logic [TIMER_W-1:0] BYTE_GAP_TIMEOUT_RST = 24'd5000;
    localparam logic [TIMER_W-1:0] TICKS_MAX            = {TIMER_W{1'b1}};

    // command bytes
    localparam logic [7:0] CMD_READ  = 8'h7A;
    localparam logic [7:0] CMD_RESET = 8'h61;

    // item kinds
    localparam logic [2:0] KIND_REQUEST = 3'd0;
    localparam logic [2:0] KIND_BYTE    = 3'd1;
    localparam logic [2:0] KIND_TICK    = 3'd2;
    localparam logic [2:0] KIND_CANCEL  = 3'd3;
    localparam logic [2:0] KIND_RESET   = 3'd4;

    // register indexes
    localparam logic REG_RESPONSE_TIMEOUT = 1'b0;
    localparam logic REG_BYTE_GAP_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [TIMER_W-1:0] response_timeout;
        logic [TIMER_W-1:0] byte_gap_timeout;
    } t_cfg;

    typedef struct packed {
        logic               send_valid;
        logic [7:0]         send_byte;
        logic               request_accepted;
        logic               value_valid;
        logic signed [15:0] heading_value;
        logic               pending;
        logic               timed_out;
        logic               last_ok;
    } t_result;

endpackage

// File: rtl/srr_cfg.sv
// ----------------------------------------------------------------------------
// srr_cfg
// apb register file holding the two timeout limits
// ----------------------------------------------------------------------------
module srr_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [srr_pkg::ADDR_W-1:0]  paddr,
    input  logic [srr_pkg::DATA_W-1:0]  pwdata,
    output logic [srr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output srr_pkg::t_cfg               o_cfg
);

    logic [srr_pkg::TIMER_W-1:0] r_response_timeout;
    logic [srr_pkg::TIMER_W-1:0] r_byte_gap_timeout;
    logic                        wr_en;
    logic                        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_response_timeout <= srr_pkg::RESPONSE_TIMEOUT_RST;
            r_byte_gap_timeout <= srr_pkg::BYTE_GAP_TIMEOUT_RST;
        end else if (wr_en) begin
            case (reg_sel)
                srr_pkg::REG_RESPONSE_TIMEOUT: begin
                    r_response_timeout <= pwdata[srr_pkg::TIMER_W-1:0];
                end
                srr_pkg::REG_BYTE_GAP_TIMEOUT: begin
                    r_byte_gap_timeout <= pwdata[srr_pkg::TIMER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            srr_pkg::REG_RESPONSE_TIMEOUT: begin
                prdata = {{(srr_pkg::DATA_W-srr_pkg::TIMER_W){1'b0}}, r_response_timeout};
            end
            srr_pkg::REG_BYTE_GAP_TIMEOUT: begin
                prdata = {{(srr_pkg::DATA_W-srr_pkg::TIMER_W){1'b0}}, r_byte_gap_timeout};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_cfg.response_timeout = r_response_timeout;
    assign o_cfg.byte_gap_timeout = r_byte_gap_timeout;

endmodule

// File: rtl/srr_core.sv
// ----------------------------------------------------------------------------
// srr_core
// read state, tick timer and flags, one item applied per fire
// ----------------------------------------------------------------------------
`include "sensor_request_response_reader_assert.svh"

module srr_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic [2:0]      i_kind,
    input  logic [7:0]      i_rx_byte,
    input  srr_pkg::t_cfg   i_cfg,
    output srr_pkg::t_result o_result
);

    srr_pkg::t_phase             r_phase, n_phase;
    logic [7:0]                  r_held, n_held;
    logic [srr_pkg::TIMER_W-1:0] r_elapsed, n_elapsed;
    logic                        r_timeout, n_timeout;
    logic                        r_success, n_success;
    logic [srr_pkg::TIMER_W-1:0] tick_count;
    logic [srr_pkg::TIMER_W-1:0] limit;
    logic                        busy;

    assign busy = (r_phase == srr_pkg::PH_HIGH) || (r_phase == srr_pkg::PH_LOW);
    assign limit = (r_phase == srr_pkg::PH_HIGH) ? i_cfg.response_timeout
                                                 : i_cfg.byte_gap_timeout;
    // saturating tick count
    assign tick_count = (r_elapsed == srr_pkg::TICKS_MAX) ? r_elapsed
                                                          : r_elapsed + 1'b1;

    always_comb begin
        n_phase   = r_phase;
        n_held    = r_held;
        n_elapsed = r_elapsed;
        n_timeout = r_timeout;
        n_success = r_success;
        o_result  = '0;
        case (i_kind)
            srr_pkg::KIND_REQUEST: begin
                if (!busy) begin
                    n_success                 = 1'b0;
                    n_timeout                 = 1'b0;
                    n_elapsed                 = '0;
                    n_phase                   = srr_pkg::PH_HIGH;
                    o_result.send_valid       = 1'b1;
                    o_result.send_byte        = srr_pkg::CMD_READ;
                    o_result.request_accepted = 1'b1;
                end
            end
            srr_pkg::KIND_BYTE: begin
                case (r_phase)
                    srr_pkg::PH_HIGH: begin
                        n_held    = i_rx_byte;
                        n_elapsed = '0;
                        n_phase   = srr_pkg::PH_LOW;
                    end
                    srr_pkg::PH_LOW: begin
                        o_result.heading_value = $signed({r_held, i_rx_byte});
                        o_result.value_valid   = 1'b1;
                        n_success              = 1'b1;
                        n_timeout              = 1'b0;
                        n_phase                = srr_pkg::PH_IDLE;
                    end
                    default: begin
                    end
                endcase
            end
            srr_pkg::KIND_TICK: begin
                if (busy) begin
                    n_elapsed = tick_count;
                    if (tick_count >= limit) begin
                        n_timeout = 1'b1;
                        n_phase   = srr_pkg::PH_IDLE;
                    end
                end
            end
            srr_pkg::KIND_CANCEL: begin
                n_phase = srr_pkg::PH_IDLE;
            end
            srr_pkg::KIND_RESET: begin
                n_phase             = srr_pkg::PH_IDLE;
                o_result.send_valid = 1'b1;
                o_result.send_byte  = srr_pkg::CMD_RESET;
            end
            default: begin
            end
        endcase
        o_result.pending   = (n_phase != srr_pkg::PH_IDLE);
        o_result.timed_out = n_timeout;
        o_result.last_ok   = n_success;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= srr_pkg::PH_IDLE;
            r_held    <= '0;
            r_elapsed <= '0;
            r_timeout <= 1'b0;
            r_success <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_held    <= n_held;
            r_elapsed <= n_elapsed;
            r_timeout <= n_timeout;
            r_success <= n_success;
        end
    end

    `SRR_ASSERT_NEXT(a_value_sets_ok, i_clk, i_rst_n, i_fire && o_result.value_valid, r_success && !r_timeout && (r_phase == srr_pkg::PH_IDLE), "completed reading did not leave ok and idle")
    `SRR_ASSERT_NEXT(a_request_starts_high, i_clk, i_rst_n, i_fire && o_result.request_accepted, (r_phase == srr_pkg::PH_HIGH) && (r_elapsed == '0), "accepted request did not arm the high-byte wait")
    `SRR_ASSERT_IMPL(a_flags_exclusive, i_clk, i_rst_n, 1'b1, !(r_timeout && r_success), "timeout and success flags both set")

endmodule

// File: rtl/sensor_request_response_reader.sv
// ----------------------------------------------------------------------------
// sensor_request_response_reader
// request/response reader for a uart heading sensor
// ----------------------------------------------------------------------------
// Each input transfer carries one item (request, received byte, tick, cancel or
// reset) and produces exactly one result transfer. The block takes one item per
// clock cycle while the output side is not stalled; an item is captured in the
// input register, then applied to the read state and written into the result
// register at the same edge once the result register can take it, so a result
// passes through the input and result registers before it is offered. A stall
// on the output holds the result register and, once the input register is also
// full, raises the input stall in the same cycle. The timeout limits sit in two
// apb registers (0x0 response timeout, 0x4 byte gap timeout, 24 bits each); the
// user must write them only while no item is in flight, which the block itself
// does not enforce. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "sensor_request_response_reader_assert.svh"

module sensor_request_response_reader (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // apb configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [srr_pkg::ADDR_W-1:0]  paddr,
    input  logic [srr_pkg::DATA_W-1:0]  pwdata,
    output logic [srr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // item input
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [2:0]                  i_kind,
    input  logic [7:0]                  i_rx_byte,
    // result output
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_send_valid,
    output logic [7:0]                  o_send_byte,
    output logic                        o_request_accepted,
    output logic                        o_value_valid,
    output logic signed [15:0]          o_heading_value,
    output logic                        o_pending,
    output logic                        o_timed_out,
    output logic                        o_last_ok
);

    srr_pkg::t_cfg    cfg;
    srr_pkg::t_result core_result;
    srr_pkg::t_result r_result;

    logic       r_in_valid;
    logic [2:0] r_kind;
    logic [7:0] r_rx_byte;
    logic       r_out_valid;
    logic       advance;
    logic       fire;

    // register file
    srr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // result register can take a new item when empty or being drained
    assign advance    = !r_out_valid || !i_out_stall;
    // the held item moves on into the result register
    assign fire       = r_in_valid && advance;
    // input register is full and cannot move on
    assign o_in_stall = r_in_valid && !advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_kind    <= i_kind;
            r_rx_byte <= i_rx_byte;
        end
    end

    // state update for the held item
    srr_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_kind    (r_kind),
        .i_rx_byte (r_rx_byte),
        .i_cfg     (cfg),
        .o_result  (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_send_valid       = r_result.send_valid;
    assign o_send_byte        = r_result.send_byte;
    assign o_request_accepted = r_result.request_accepted;
    assign o_value_valid      = r_result.value_valid;
    assign o_heading_value    = r_result.heading_value;
    assign o_pending          = r_result.pending;
    assign o_timed_out        = r_result.timed_out;
    assign o_last_ok          = r_result.last_ok;

    // a held item is never dropped while waiting
    `SRR_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, o_in_stall, r_in_valid && $stable(r_kind) && $stable(r_rx_byte), "stalled input item lost")
    // a waiting result is never overwritten
    `SRR_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid && $stable(r_result), "stalled result overwritten")

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the uart heading sensor request/response reader
// ----------------------------------------------------------------------------
// Items are driven one transfer at a time with random sender gaps. The result
// side is stalled at random. Every accepted item is run through a predictor
// of the read sequencer (idle, high-byte wait, low-byte wait, tick timeouts,
// sticky flags). Its result goes into an in-order queue, and each result
// transfer is checked field by field against the oldest queued entry. The
// timeout limits are rewritten over apb between phases, once the block has
// drained.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // predictor of the read sequencer plus the queue of results still owed
    class heading_reader_model;
        logic [srr_pkg::TIMER_W-1:0] response_limit;
        logic [srr_pkg::TIMER_W-1:0] gap_limit;
        srr_pkg::t_phase             phase;
        logic [7:0]                  high_byte;
        logic [srr_pkg::TIMER_W-1:0] ticks;
        logic                        timeout_seen;
        logic                        read_good;
        srr_pkg::t_result            due_replies[$];
        int                          replies_seen;
        int                          mismatches;

        function new();
            response_limit = srr_pkg::RESPONSE_TIMEOUT_RST;
            gap_limit      = srr_pkg::BYTE_GAP_TIMEOUT_RST;
            phase          = srr_pkg::PH_IDLE;
            high_byte      = '0;
            ticks          = '0;
            timeout_seen   = 1'b0;
            read_good      = 1'b0;
            replies_seen   = 0;
            mismatches     = 0;
        endfunction

        // the block keeps only the low 24 bits of the written word
        function void set_limit(logic idx, logic [srr_pkg::DATA_W-1:0] value);
            if (idx == srr_pkg::REG_RESPONSE_TIMEOUT) begin
                response_limit = value[srr_pkg::TIMER_W-1:0];
            end else begin
                gap_limit = value[srr_pkg::TIMER_W-1:0];
            end
        endfunction

        // an item has been accepted: advance the sequencer, queue its result
        function void apply_item(logic [2:0] kind, logic [7:0] rx);
            srr_pkg::t_result            r;
            logic [srr_pkg::TIMER_W-1:0] lim;
            logic                        busy;
            r    = '0;
            busy = (phase != srr_pkg::PH_IDLE);
            case (kind)
                srr_pkg::KIND_REQUEST: begin
                    // ignored while a read is outstanding
                    if (!busy) begin
                        read_good          = 1'b0;
                        timeout_seen       = 1'b0;
                        ticks              = '0;
                        phase              = srr_pkg::PH_HIGH;
                        r.send_valid       = 1'b1;
                        r.send_byte        = srr_pkg::CMD_READ;
                        r.request_accepted = 1'b1;
                    end
                end
                srr_pkg::KIND_BYTE: begin
                    if (phase == srr_pkg::PH_HIGH) begin
                        high_byte = rx;
                        ticks     = '0;
                        phase     = srr_pkg::PH_LOW;
                    end else if (phase == srr_pkg::PH_LOW) begin
                        r.heading_value = {high_byte, rx};
                        r.value_valid   = 1'b1;
                        read_good       = 1'b1;
                        timeout_seen    = 1'b0;
                        phase           = srr_pkg::PH_IDLE;
                    end
                end
                srr_pkg::KIND_TICK: begin
                    if (busy) begin
                        lim = (phase == srr_pkg::PH_HIGH) ? response_limit : gap_limit;
                        if (ticks != srr_pkg::TICKS_MAX) begin
                            ticks = ticks + 1'b1;
                        end
                        if (ticks >= lim) begin
                            timeout_seen = 1'b1;
                            phase        = srr_pkg::PH_IDLE;
                        end
                    end
                end
                srr_pkg::KIND_CANCEL: begin
                    phase = srr_pkg::PH_IDLE;
                end
                srr_pkg::KIND_RESET: begin
                    phase        = srr_pkg::PH_IDLE;
                    r.send_valid = 1'b1;
                    r.send_byte  = srr_pkg::CMD_RESET;
                end
                default: begin
                end
            endcase
            r.pending   = (phase != srr_pkg::PH_IDLE);
            r.timed_out = timeout_seen;
            r.last_ok   = read_good;
            due_replies.push_back(r);
        endfunction

        task report(string what);
            mismatches++;
            $display("mismatch at result %0d: %s", replies_seen, what);
        endtask

        task compare(string field, logic [15:0] got, logic [15:0] want);
            if (got !== want) begin
                report($sformatf("%s got %0h, want %0h", field, got, want));
            end
        endtask

        task match_result(srr_pkg::t_result got);
            srr_pkg::t_result want;
            replies_seen++;
            if (due_replies.size() == 0) begin
                report("result transfer with nothing awaited");
                return;
            end
            want = due_replies.pop_front();
            compare("send_valid", got.send_valid, want.send_valid);
            compare("send_byte", got.send_byte, want.send_byte);
            compare("request_accepted", got.request_accepted, want.request_accepted);
            compare("value_valid", got.value_valid, want.value_valid);
            compare("heading_value", got.heading_value, want.heading_value);
            compare("pending", got.pending, want.pending);
            compare("timed_out", got.timed_out, want.timed_out);
            compare("last_ok", got.last_ok, want.last_ok);
        endtask
    endclass

    // every input starts at a known value
    logic                          i_clk     = 1'b0;
    logic                          i_rst_n   = 1'b0;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [srr_pkg::ADDR_W-1:0]    paddr     = '0;
    logic [srr_pkg::DATA_W-1:0]    pwdata    = '0;
    logic [srr_pkg::DATA_W-1:0]    prdata;
    logic                          pready;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    logic [2:0]                    i_kind      = '0;
    logic [7:0]                    i_rx_byte   = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic                          o_send_valid;
    logic [7:0]                    o_send_byte;
    logic                          o_request_accepted;
    logic                          o_value_valid;
    logic signed [15:0]            o_heading_value;
    logic                          o_pending;
    logic                          o_timed_out;
    logic                          o_last_ok;

    heading_reader_model   reader;

    // idle odds out of a hundred, per cycle
    int                    send_idle = 16;
    int                    recv_idle = 48;
    // input transfers made, and those of a defined kind
    int                    items_accepted = 0;
    int                    items_counted  = 0;

    always #2 i_clk = ~i_clk;

    sensor_request_response_reader i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_kind             (i_kind),
        .i_rx_byte          (i_rx_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_send_valid       (o_send_valid),
        .o_send_byte        (o_send_byte),
        .o_request_accepted (o_request_accepted),
        .o_value_valid      (o_value_valid),
        .o_heading_value    (o_heading_value),
        .o_pending          (o_pending),
        .o_timed_out        (o_timed_out),
        .o_last_ok          (o_last_ok)
    );

    // both handshakes are sampled at the edge, on the values that held just
    // before it; the result-side stall is redrawn every cycle
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                reader.apply_item(i_kind, i_rx_byte);
            end
            if (o_out_valid && !i_out_stall) begin
                reader.match_result('{o_send_valid, o_send_byte, o_request_accepted,
                                      o_value_valid, o_heading_value, o_pending,
                                      o_timed_out, o_last_ok});
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < recv_idle);
    end

    // one input transfer, after a random gap; payload held while stalled
    task drive_item(logic [2:0] kind, logic [7:0] rx);
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_rx_byte  <= rx;
        do @(posedge i_clk); while (o_in_stall);
        items_accepted++;
        if (kind <= srr_pkg::KIND_RESET) begin
            items_counted++;
        end
    endtask

    // hold the sender off until every item has come back as a result
    task await_quiet();
        while (reader.replies_seen != items_accepted) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // apb write: setup then access; spare bits above the limit are random
    task write_limit(logic idx, logic [srr_pkg::TIMER_W-1:0] value);
        logic [srr_pkg::DATA_W-1:0] word;
        word                       = $urandom;
        word[srr_pkg::TIMER_W-1:0] = value;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        reader.set_limit(idx, word);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // anything at all, undefined kinds included
    task stray_item();
        drive_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    endtask

    // mostly a wait well inside the limit, now and then a run onto it
    function automatic int tick_run(int lim);
        if (lim <= 12 && $urandom_range(0, 3) == 0) begin
            return lim + $urandom_range(0, 1);
        end
        return $urandom_range(0, (lim > 6) ? 6 : lim - 1);
    endfunction

    // request, wait, high byte, wait, low byte, with the odd stray in between
    task read_sequence();
        int n;
        drive_item(srr_pkg::KIND_REQUEST, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 8) begin
            stray_item();
        end
        n = tick_run(reader.response_limit);
        repeat (n) drive_item(srr_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
        drive_item(srr_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 8) begin
            stray_item();
        end
        n = tick_run(reader.gap_limit);
        repeat (n) drive_item(srr_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
        drive_item(srr_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
    endtask

    // drain, set both limits, then random reads until enough items went in
    task run_phase(logic [srr_pkg::TIMER_W-1:0] resp, logic [srr_pkg::TIMER_W-1:0] gap,
                   int s_idle, int r_idle, int n);
        int target;
        await_quiet();
        write_limit(srr_pkg::REG_RESPONSE_TIMEOUT, resp);
        write_limit(srr_pkg::REG_BYTE_GAP_TIMEOUT, gap);
        send_idle = s_idle;
        recv_idle = r_idle;
        target    = items_counted + n;
        while (items_counted < target) begin
            if ($urandom_range(0, 39) == 0) begin
                await_quiet();
            end
            if ($urandom_range(0, 99) < 80) begin
                read_sequence();
            end else begin
                stray_item();
            end
        end
    endtask

    initial begin : stimulus
        reader = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset limits: odd kinds, idle traffic, busy request, value extremes
        drive_item(3'd7, 8'h00);
        drive_item(srr_pkg::KIND_BYTE, 8'hA5);
        drive_item(srr_pkg::KIND_TICK, 8'hFF);
        drive_item(srr_pkg::KIND_REQUEST, 8'h00);
        drive_item(srr_pkg::KIND_REQUEST, 8'hFF);
        drive_item(srr_pkg::KIND_TICK, 8'h5A);
        drive_item(srr_pkg::KIND_BYTE, 8'hFF);
        drive_item(srr_pkg::KIND_BYTE, 8'h80);
        drive_item(srr_pkg::KIND_REQUEST, 8'h3C);
        drive_item(srr_pkg::KIND_BYTE, 8'h7F);
        drive_item(srr_pkg::KIND_BYTE, 8'hFF);
        drive_item(srr_pkg::KIND_REQUEST, 8'hC3);
        drive_item(srr_pkg::KIND_BYTE, 8'h80);
        drive_item(srr_pkg::KIND_BYTE, 8'h00);
        drive_item(srr_pkg::KIND_REQUEST, 8'h01);
        drive_item(srr_pkg::KIND_CANCEL, 8'hFE);
        drive_item(srr_pkg::KIND_RESET, 8'h00);
        drive_item(srr_pkg::KIND_REQUEST, 8'h00);
        drive_item(srr_pkg::KIND_RESET, 8'hFF);

        // short limits: response timeout, then gap timeout on the first tick
        await_quiet();
        write_limit(srr_pkg::REG_RESPONSE_TIMEOUT, 24'd2);
        write_limit(srr_pkg::REG_BYTE_GAP_TIMEOUT, 24'd1);
        drive_item(srr_pkg::KIND_REQUEST, 8'h00);
        drive_item(srr_pkg::KIND_TICK, 8'h00);
        drive_item(srr_pkg::KIND_TICK, 8'h00);
        drive_item(srr_pkg::KIND_REQUEST, 8'h00);
        drive_item(srr_pkg::KIND_BYTE, 8'h96);
        drive_item(srr_pkg::KIND_TICK, 8'h00);

        // sender idles lightly, receiver heavily, then the other way round
        run_phase(24'd1, 24'd1, 16, 48, 170);
        run_phase(srr_pkg::TICKS_MAX, srr_pkg::TICKS_MAX, 16, 48, 170);
        run_phase(24'd7, 24'd4, 48, 16, 170);
        run_phase(24'($urandom_range(1, 12)), 24'($urandom_range(1, 12)), 48, 16, 170);
        // back to back on both sides
        run_phase(24'd5, 24'd2, 0, 0, 170);

        await_quiet();
        repeat (10) @(posedge i_clk);
        if (reader.mismatches == 0 && reader.due_replies.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // hung handshake guard, far beyond the slowest correct run
    initial begin : watchdog
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/srr_pkg.sv
rtl/srr_cfg.sv
rtl/srr_core.sv
rtl/sensor_request_response_reader.sv
bench/tb_top.sv
